[rtl/spq_pkg.sv]
package spq_pkg;

  localparam int PRIO_BITS = 16;
  localparam int DATA_BITS = 32;
  localparam int CNT_BITS  = 5;

  localparam logic [CNT_BITS-1:0] LIMIT_RESET = CNT_BITS'(16);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_TOP
  } state_t;

  typedef struct packed {
    cmd_e                 command;
    logic [PRIO_BITS-1:0] priority_req;
    logic [DATA_BITS-1:0] payload;
  } req_t;

  typedef struct packed {
    logic                 ok;
    logic [PRIO_BITS-1:0] out_priority;
    logic [DATA_BITS-1:0] out_payload;
    logic [CNT_BITS-1:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic [PRIO_BITS-1:0] prio;
    logic [DATA_BITS-1:0] data;
  } entry_t;

endpackage

[rtl/sorted_priority_queue.sv]
// done is registered straight from the accepting edge for a refused op or an insert into an
// empty queue; a pop/peek passes through ST_TOP first, and an insert that moves stored
// entries walks ST_SCAN down them, then ST_PLACE if every one moves. busy stays high until then.
// No op is accepted while busy; the insert scan does one entry-memory read and write a cycle.
// Reset clears the count and sets the limit to 16; the entry memory is not cleared.
// The receiver cannot stall: each result is valid for the single cycle that done is high.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  req_t                req,
  output logic                done,
  output rsp_t                rsp,
  input  logic                cfg_we,
  input  logic [CNT_BITS-1:0] cfg_wdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t              state, state_next;
  logic [CNT_BITS-1:0] count, count_next;
  logic [CNT_BITS-1:0] limit;
  logic [CNT_BITS-1:0] idx, idx_next;
  req_t                req_q;
  logic                done_next;
  rsp_t                rsp_next;

  entry_t              mem [DEPTH];
  entry_t              rd_data;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  entry_t              mem_wdata;

  logic                full, empty, accept, ins_go, top_go, shift;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign empty  = (count == '0);
  assign full   = (count >= limit) || (32'(count) >= DEPTH);
  assign ins_go = accept && (req.command == CMD_INSERT) && !full && !empty;
  assign top_go = accept && ((req.command == CMD_POP) || (req.command == CMD_PEEK)) && !empty;
  // stored entry with equal or greater priority moves up one slot
  assign shift  = (rd_data.prio >= req_q.priority_req);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (ins_go) begin
          state_next = ST_SCAN;
        end else if (top_go) begin
          state_next = ST_TOP;
        end
      end
      ST_SCAN: begin
        if (!shift) begin
          state_next = ST_IDLE;
        end else if (idx == '0) begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: state_next = ST_IDLE;
      ST_TOP:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '{prio: req_q.priority_req, data: req_q.payload};
    mem_re    = 1'b0;
    mem_raddr = '0;
    count_next = count;
    idx_next   = idx;
    done_next  = 1'b0;
    rsp_next   = '0;
    rsp_next.occupancy = count;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.command)
            CMD_INSERT: begin
              if (full) begin
                done_next = 1'b1;
              end else if (empty) begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = '{prio: req.priority_req, data: req.payload};
                count_next = count + 1'b1;
                done_next  = 1'b1;
                rsp_next.ok        = 1'b1;
                rsp_next.occupancy = count + 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(count - 1'b1);
                idx_next  = count - 1'b1;
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (empty) begin
                done_next = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(count - 1'b1);
              end
            end
            default: done_next = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx + 1'b1);
        if (shift) begin
          mem_wdata = rd_data;
          // reads walk down while writes land two slots above: no overlap
          if (idx != '0) begin
            mem_re    = 1'b1;
            mem_raddr = AW'(idx - 1'b1);
            idx_next  = idx - 1'b1;
          end
        end else begin
          count_next = count + 1'b1;
          done_next  = 1'b1;
          rsp_next.ok        = 1'b1;
          rsp_next.occupancy = count + 1'b1;
        end
      end
      ST_PLACE: begin
        mem_we     = 1'b1;
        mem_waddr  = '0;
        count_next = count + 1'b1;
        done_next  = 1'b1;
        rsp_next.ok        = 1'b1;
        rsp_next.occupancy = count + 1'b1;
      end
      ST_TOP: begin
        done_next = 1'b1;
        rsp_next.ok           = 1'b1;
        rsp_next.out_priority = rd_data.prio;
        rsp_next.out_payload  = rd_data.data;
        if (req_q.command == CMD_POP) begin
          count_next         = count - 1'b1;
          rsp_next.occupancy = count - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      limit <= LIMIT_RESET;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    idx <= idx_next;
    rsp <= rsp_next;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= DEPTH)
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + 1'b1 ||
                     count == $past(count) - 1'b1))
    else $error("entry count moved by more than one");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && done |-> $past(start) || $past(busy))
    else $error("result without a command in flight");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    done && !rsp.ok |-> rsp.out_priority == '0 && rsp.out_payload == '0)
    else $error("refused result carries entry data");

  a_scan_index: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> idx < count)
    else $error("scan index outside stored entries");
`endif

endmodule

[verif/tb.sv]
module tb
  import spq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int NPHASE = 9;
  localparam int PHASE_ITEMS = 175;
  localparam int SETTLE_CYCLES = 24;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  req_t                req;
  logic                done;
  rsp_t                rsp;
  logic                cfg_we;
  logic [CNT_BITS-1:0] cfg_wdata;

  sorted_priority_queue #(.DEPTH(QDEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor state: slot 0 lowest priority, slot held-1 highest.
  entry_t              slots [QDEPTH];
  int                  held;
  logic [CNT_BITS-1:0] limit_reg;

  rsp_t pending_answers[$];
  int   mismatch_cnt;
  int   beat_cnt;

  // Directed stimulus table.
  req_t script_ops[$];
  rsp_t script_answers[$];
  bit   script_typed[$];

  int phase_limit [NPHASE] = '{16, 31, 5, 0, 1, 16, 20, -1, 16};
  int phase_ins   [NPHASE] = '{70, 85, 55, 40, 60, 45, 70, 55, 50};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rsp_t queue_answer(req_t r);
    rsp_t a;
    int   pos;
    int   i;
    int   cap;
    a = '0;
    cap = (limit_reg < QDEPTH) ? int'(limit_reg) : QDEPTH;
    case (r.command)
      CMD_INSERT: begin
        if (held < cap) begin
          pos = 0;
          while (pos < held && slots[pos].prio < r.priority_req) pos++;
          for (i = held; i > pos; i--) slots[i] = slots[i-1];
          slots[pos].prio = r.priority_req;
          slots[pos].data = r.payload;
          held++;
          a.ok = 1'b1;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (held > 0) begin
          a.ok = 1'b1;
          a.out_priority = slots[held-1].prio;
          a.out_payload = slots[held-1].data;
          if (r.command == CMD_POP) held--;
        end
      end
      default: ;
    endcase
    a.occupancy = CNT_BITS'(held);
    return a;
  endfunction

  function automatic req_t rand_op(int ins_pct);
    req_t r;
    int   roll;
    roll = $urandom_range(99);
    if (roll < 3) begin
      r.command = cmd_e'(CMD_UNUSED);
    end else if ($urandom_range(99) < ins_pct) begin
      r.command = CMD_INSERT;
    end else begin
      r.command = ($urandom_range(3) == 0) ? CMD_PEEK : CMD_POP;
    end
    case ($urandom_range(3))
      0: r.priority_req = PRIO_BITS'($urandom_range(7));  // lots of ties
      1: r.priority_req = $urandom_range(1) ? '1 : '0;
      default: r.priority_req = PRIO_BITS'($urandom);
    endcase
    r.payload = $urandom;
    return r;
  endfunction

  task automatic add_row(bit typed, logic [1:0] cmd, logic [PRIO_BITS-1:0] prio,
                         logic [DATA_BITS-1:0] data, logic ok,
                         logic [PRIO_BITS-1:0] oprio, logic [DATA_BITS-1:0] odata,
                         logic [CNT_BITS-1:0] occ);
    req_t r;
    rsp_t a;
    r.command = cmd_e'(cmd);
    r.priority_req = prio;
    r.payload = data;
    a.ok = ok;
    a.out_priority = oprio;
    a.out_payload = odata;
    a.occupancy = occ;
    script_ops.push_back(r);
    script_answers.push_back(a);
    script_typed.push_back(typed);
  endtask

  // Returns at the edge that accepts the beat; start stays high.
  task automatic send_op(req_t r, bit typed, rsp_t typed_answer);
    rsp_t predicted;
    @(negedge clk);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = queue_answer(r);
    pending_answers.push_back(typed ? typed_answer : predicted);
  endtask

  task automatic idle_gap();
    int n;
    if ($urandom_range(3) == 0) begin
      n = $urandom_range(1, 16);
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [CNT_BITS-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    limit_reg = v;
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      beat_cnt++;
      if (pending_answers.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("beat %0d: result with nothing pending, got %p", beat_cnt, rsp);
      end else begin
        automatic rsp_t want = pending_answers.pop_front();
        if (rsp.ok !== want.ok || rsp.out_priority !== want.out_priority ||
            rsp.out_payload !== want.out_payload || rsp.occupancy !== want.occupancy) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("beat %0d: ok %b/%b prio %h/%h payload %h/%h occ %0d/%0d (exp/act)",
                     beat_cnt, want.ok, rsp.ok, want.out_priority, rsp.out_priority,
                     want.out_payload, rsp.out_payload, want.occupancy, rsp.occupancy);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("tb: errors");
    $finish;
  end

  initial begin
    int   p;
    int   n;
    int   lim;
    rsp_t none;

    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    held = 0;
    limit_reg = LIMIT_RESET;
    mismatch_cnt = 0;
    beat_cnt = 0;
    none = '0;
    for (n = 0; n < QDEPTH; n++) slots[n] = '0;

    // empty queue, unused command, extremes, ties on equal priority
    add_row(1, CMD_POP,    16'h0,    32'h0,        1'b0, 16'h0,    32'h0,        5'd0);
    add_row(1, CMD_PEEK,   16'h0,    32'h0,        1'b0, 16'h0,    32'h0,        5'd0);
    add_row(1, CMD_UNUSED, 16'hffff, 32'hffffffff, 1'b0, 16'h0,    32'h0,        5'd0);
    add_row(1, CMD_INSERT, 16'hffff, 32'hffffffff, 1'b1, 16'h0,    32'h0,        5'd1);
    add_row(1, CMD_PEEK,   16'h0,    32'h0,        1'b1, 16'hffff, 32'hffffffff, 5'd1);
    add_row(1, CMD_INSERT, 16'h0,    32'h0,        1'b1, 16'h0,    32'h0,        5'd2);
    add_row(1, CMD_INSERT, 16'h0,    32'h1,        1'b1, 16'h0,    32'h0,        5'd3);
    add_row(1, CMD_INSERT, 16'h8000, 32'ha5a5a5a5, 1'b1, 16'h0,    32'h0,        5'd4);
    add_row(0, CMD_INSERT, 16'h8000, 32'h5a5a5a5a, 1'b0, 16'h0,    32'h0,        5'd0);
    add_row(0, CMD_INSERT, 16'h7fff, 32'h12345678, 1'b0, 16'h0,    32'h0,        5'd0);
    add_row(1, CMD_UNUSED, 16'h1234, 32'h9,        1'b0, 16'h0,    32'h0,        5'd6);
    add_row(1, CMD_POP,    16'h0,    32'h0,        1'b1, 16'hffff, 32'hffffffff, 5'd5);
    add_row(0, CMD_POP,    16'h0,    32'h0,        1'b0, 16'h0,    32'h0,        5'd0);
    add_row(0, CMD_PEEK,   16'h0,    32'h0,        1'b0, 16'h0,    32'h0,        5'd0);
    add_row(0, CMD_POP,    16'h0,    32'h0,        1'b0, 16'h0,    32'h0,        5'd0);
    add_row(0, CMD_INSERT, 16'h7fff, 32'hdeadbeef, 1'b0, 16'h0,    32'h0,        5'd0);
    add_row(0, CMD_POP,    16'h0,    32'h0,        1'b0, 16'h0,    32'h0,        5'd0);
    add_row(0, CMD_POP,    16'h0,    32'h0,        1'b0, 16'h0,    32'h0,        5'd0);
    add_row(0, CMD_POP,    16'h0,    32'h0,        1'b0, 16'h0,    32'h0,        5'd0);
    add_row(0, CMD_PEEK,   16'h0,    32'h0,        1'b0, 16'h0,    32'h0,        5'd0);
    add_row(0, CMD_POP,    16'h0,    32'h0,        1'b0, 16'h0,    32'h0,        5'd0);
    add_row(1, CMD_POP,    16'h0,    32'h0,        1'b0, 16'h0,    32'h0,        5'd0);

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    for (n = 0; n < script_ops.size(); n++) begin
      send_op(script_ops[n], script_typed[n], script_answers[n]);
      idle_gap();
    end

    // Each phase starts from an idle block: the limit is only changed between phases.
    for (p = 0; p < NPHASE; p++) begin
      drain();
      lim = phase_limit[p];
      if (lim < 0) lim = $urandom_range(31);
      write_limit(CNT_BITS'(lim));
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_op(rand_op(phase_ins[p]), 1'b0, none);
        if (p != NPHASE - 1) idle_gap();
      end
    end
    drain();

    if (mismatch_cnt == 0 && pending_answers.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[sorted_priority_queue.f]
rtl/spq_pkg.sv
rtl/sorted_priority_queue.sv
verif/tb.sv
